### src/bbd_pkg.sv
// Shared types, constants and fixed-point helpers for the boxcar/biquad decimator.
// No dependencies; imported by every module of the block.
package bbd_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int SIG_W        = 48;
  localparam int COEF_W       = 32;
  localparam int LEN_W        = 13;
  localparam int CNT_W        = 12;
  localparam int NSEC_W       = 4;
  localparam int SEC_W        = 3;
  localparam int CADDR_W      = 6;
  localparam int COEF_DEPTH   = MAX_SECTIONS * 5;
  localparam int BOX_W        = 37;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_DATA_W    = 112;

  localparam logic [LEN_W-1:0]  MAX_RATIO = 13'd4096;
  localparam logic [NSEC_W-1:0] NSEC_MAX  = 4'(MAX_SECTIONS);

  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NSEC    = 2'd2;

  // coefficient slots
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  typedef logic signed [SIG_W-1:0] sig_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_VALUE  = 2'd1,
    CMD_PRIME  = 2'd2,
    CMD_COEF   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    sig_t                          value;
    logic [CADDR_W-1:0]            caddr;
    logic signed [COEF_W-1:0]      cword;
  } job_t;

  typedef struct packed {
    logic [LEN_W-1:0]  box_len;
    logic [LEN_W-1:0]  dec_len;
    logic [NSEC_W-1:0] nsec;
  } cfg_t;

  function automatic logic [CADDR_W-1:0] coef_addr(input logic [SEC_W-1:0] sec,
                                                  input logic [2:0] slot);
    logic [CADDR_W-1:0] s;
    s = {3'b000, sec};
    return (s << 2) + s + {3'b000, slot};
  endfunction

  // multiply order within a section: b0, b1, a1, b2, a2
  function automatic logic [2:0] step_slot(input logic [2:0] step);
    logic [2:0] r;
    case (step)
      3'd0:    r = SLOT_B0;
      3'd1:    r = SLOT_B1;
      3'd2:    r = SLOT_A1;
      3'd3:    r = SLOT_B2;
      default: r = SLOT_A2;
    endcase
    return r;
  endfunction

  function automatic sig_t sat_add(input sig_t a, input sig_t b);
    logic signed [SIG_W:0] s;
    s = {a[SIG_W-1], a} + {b[SIG_W-1], b};
    if (s[SIG_W] != s[SIG_W-1]) return s[SIG_W] ? SIG_MIN : SIG_MAX;
    return s[SIG_W-1:0];
  endfunction

  function automatic sig_t sat_sub(input sig_t a, input sig_t b);
    logic signed [SIG_W:0] s;
    s = {a[SIG_W-1], a} - {b[SIG_W-1], b};
    if (s[SIG_W] != s[SIG_W-1]) return s[SIG_W] ? SIG_MIN : SIG_MAX;
    return s[SIG_W-1:0];
  endfunction

  function automatic sig_t sat_wide(input logic signed [63:0] v);
    if ((&v[63:SIG_W-1]) || !(|v[63:SIG_W-1])) return v[SIG_W-1:0];
    return v[63] ? SIG_MIN : SIG_MAX;
  endfunction

endpackage

### src/bbd_front.sv
// Front end: takes input words, decodes the command and drops those that do nothing.
// Depends on bbd_pkg; feeds bbd_queue.
module bbd_front (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [1:0]               in_tuser,  // command
  // raw_sample[23:0], direct_value[71:24], coef_section[74:72],
  // coef_slot[77:75], coef_word[109:78], zero pad[111:110]
  input  logic [111:0]             in_tdata,
  input  bbd_pkg::cfg_t            cfg,
  input  logic                     q_full,
  output logic                     q_push,
  output bbd_pkg::job_t            q_job
);
  import bbd_pkg::*;

  logic       design_ok;
  logic       addr_ok;
  logic       keep;
  logic [2:0] sec;
  logic [2:0] slot;

  assign sec  = in_tdata[74:72];
  assign slot = in_tdata[77:75];

  assign design_ok = (cfg.box_len != '0) && (cfg.dec_len != '0) && (cfg.nsec <= NSEC_MAX);
  assign addr_ok   = (slot <= SLOT_A2) && (int'(sec) < MAX_SECTIONS);

  always_comb begin
    case (cmd_t'(in_tuser))
      CMD_SAMPLE: keep = design_ok;
      CMD_VALUE:  keep = design_ok;
      CMD_PRIME:  keep = 1'b1;
      CMD_COEF:   keep = addr_ok;
      default:    keep = 1'b0;
    endcase
  end

  assign in_tready    = !q_full;
  assign q_push       = in_tvalid && !q_full && keep;
  assign q_job.op     = cmd_t'(in_tuser);
  assign q_job.sample = in_tdata[23:0];
  assign q_job.value  = in_tdata[71:24];
  assign q_job.caddr  = coef_addr(sec, slot);
  assign q_job.cword  = in_tdata[109:78];

endmodule

### src/bbd_queue.sv
// Two-entry job queue between front and back end.
// Depends on bbd_pkg.
module bbd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbd_pkg::job_t push_job,
  input  logic          pop,
  output bbd_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import bbd_pkg::*;

  job_t       ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_job;
  end

  assign pop_job = ent_r[rd_r];
  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);

endmodule

### src/bbd_mul.sv
// Q32.16 by Q2.30 multiplier: 16 bits of the signal per cycle, then round and saturate.
// Depends on bbd_pkg.
module bbd_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bbd_pkg::sig_t       a,
  input  logic signed [63:0]  b,
  output logic                done,
  output bbd_pkg::sig_t       res
);
  import bbd_pkg::*;

  logic           busy_r;
  logic [1:0]     ph_r;
  logic           done_r;
  logic           neg_r;
  logic [47:0]    ua_r;
  logic [63:0]    ub_r;
  logic [111:0]   acc_r;
  sig_t           res_r;
  logic [79:0]    pp;
  logic [111:0]   rsum;
  logic [81:0]    rq;
  logic [47:0]    lim;
  logic [47:0]    mag;

  assign pp   = {32'b0, ua_r[47:32]} * {16'b0, ub_r};
  assign rsum = acc_r + 112'(1 << 29);
  assign rq   = rsum[111:30];
  assign lim  = neg_r ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
  assign mag  = ((rq[81:48] != '0) || (rq[47:0] > lim)) ? lim : rq[47:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      neg_r <= a[47] ^ b[63];
      ua_r  <= a[47] ? (~a + 48'd1) : a;
      ub_r  <= b[63] ? (~b + 64'd1) : b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (ph_r != 2'd3) begin
        acc_r <= {acc_r[95:0], 16'b0} + {32'b0, pp};
        ua_r  <= {ua_r[31:0], 16'b0};
      end else begin
        res_r <= neg_r ? sig_t'(-mag) : sig_t'(mag);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### src/bbd_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on bbd_pkg.
module bbd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [62:0]        dvd,
  input  logic [34:0]        dvs,
  input  logic               neg,
  output logic               done,
  output logic signed [63:0] quot
);
  import bbd_pkg::*;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic        neg_r;
  logic [62:0] q_r;
  logic [34:0] rem_r;
  logic [34:0] dvs_r;
  logic [35:0] sh;
  logic        ge;

  assign sh = {rem_r, q_r[62]};
  assign ge = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd62;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= ge ? 35'(sh - {1'b0, dvs_r}) : sh[34:0];
      q_r   <= {q_r[61:0], ge};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

### src/bbd_back.sv
// Back end: boxcar sum, biquad cascade and priming sequencer, coefficient store, output word.
// Depends on bbd_pkg, bbd_mul and bbd_div.
module bbd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bbd_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  bbd_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata  // filtered
);
  import bbd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SEC, ST_GFETCH, ST_GACC, ST_FETCH, ST_MULGO, ST_MULWAIT, ST_EMIT
  } state_t;

  state_t                   state_r, state_nxt;
  sig_t                     x_r, x_nxt, y_r, y_nxt, t_r, t_nxt, u_r, u_nxt;
  logic signed [63:0]       gain_r, gain_nxt;
  logic signed [34:0]       num_r, num_nxt, den_r, den_nxt;
  logic [NSEC_W-1:0]        sec_r, sec_nxt;
  logic [2:0]               step_r, step_nxt;
  logic                     prime_r, prime_nxt;
  logic signed [BOX_W-1:0]  box_total_r, box_total_nxt;
  logic [CNT_W-1:0]         box_count_r, box_count_nxt;
  logic [CNT_W-1:0]         dump_count_r, dump_count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  sig_t                     out_data_r, out_data_nxt;
  logic [CADDR_W-1:0]       caddr_r, caddr_nxt;
  sig_t                     s1_r [MAX_SECTIONS];
  sig_t                     s2_r [MAX_SECTIONS];
  sig_t                     s1_nxt [MAX_SECTIONS];
  sig_t                     s2_nxt [MAX_SECTIONS];

  logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]    coef_vld_r;
  logic signed [COEF_W-1:0] coef_q_r;
  logic                     coef_we;

  logic               mul_start, mul_done;
  sig_t               mul_a, mul_res;
  logic signed [63:0] mul_b;
  logic               div_start, div_done, div_neg;
  logic [62:0]        div_dvd;
  logic [34:0]        div_dvs;
  logic signed [63:0] div_quot;

  logic [LEN_W-1:0]        box_len, dec_len;
  logic [NSEC_W-1:0]       nsec_lim;
  logic [SEC_W-1:0]        si;
  logic signed [BOX_W-1:0] tot_sum;
  logic [BOX_W-1:0]        tot_mag;
  logic [LEN_W-1:0]        cnt_inc, dcnt_inc;
  logic signed [34:0]      num_new, den_new, cq_ext;
  logic [34:0]             num_mag, den_mag;
  sig_t                    tt, s2n;

  assign box_len  = (cfg.box_len > MAX_RATIO) ? MAX_RATIO : cfg.box_len;
  assign dec_len  = (cfg.dec_len > MAX_RATIO) ? MAX_RATIO : cfg.dec_len;
  assign nsec_lim = (cfg.nsec > NSEC_MAX) ? NSEC_MAX : cfg.nsec;
  assign si       = sec_r[SEC_W-1:0];

  assign tot_sum  = box_total_r + BOX_W'(q_job.sample);
  assign tot_mag  = tot_sum[BOX_W-1] ? BOX_W'(-tot_sum) : tot_sum;
  assign cnt_inc  = {1'b0, box_count_r} + 13'd1;
  assign dcnt_inc = {1'b0, dump_count_r} + 13'd1;
  assign cq_ext   = 35'(coef_q_r);
  assign num_new  = (step_r < 3'd3) ? num_r + cq_ext : num_r;
  assign den_new  = (step_r < 3'd3) ? den_r : den_r + cq_ext;
  assign num_mag  = num_new[34] ? 35'(-num_new) : num_new;
  assign den_mag  = den_new[34] ? 35'(-den_new) : den_new;
  assign tt       = sat_sub(t_r, mul_res);
  assign s2n      = sat_sub(u_r, mul_res);

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    gain_nxt       = gain_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    sec_nxt        = sec_r;
    step_nxt       = step_r;
    prime_nxt      = prime_r;
    box_total_nxt  = box_total_r;
    box_count_nxt  = box_count_r;
    dump_count_nxt = dump_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    caddr_nxt      = caddr_r;
    s1_nxt         = s1_r;
    s2_nxt         = s2_r;
    q_pop          = 1'b0;
    coef_we        = 1'b0;
    mul_start      = 1'b0;
    mul_a          = (step_r == 3'd2 || step_r == 3'd4) ? y_r : x_r;
    mul_b          = (prime_r && step_r == 3'd0) ? gain_r : 64'(coef_q_r);
    div_start      = 1'b0;
    div_dvd        = {10'b0, tot_mag[36:0], 16'b0};
    div_dvs        = {22'b0, box_len};
    div_neg        = tot_sum[BOX_W-1];

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          sec_nxt = '0;
          case (q_job.op)
            CMD_COEF: coef_we = 1'b1;
            CMD_SAMPLE: begin
              if (cnt_inc >= box_len) begin
                box_total_nxt = '0;
                box_count_nxt = '0;
                prime_nxt     = 1'b0;
                div_start     = 1'b1;
                state_nxt     = ST_DIV;
              end else begin
                box_total_nxt = tot_sum;
                box_count_nxt = cnt_inc[CNT_W-1:0];
              end
            end
            CMD_VALUE: begin
              x_nxt     = q_job.value;
              prime_nxt = 1'b0;
              state_nxt = ST_SEC;
            end
            CMD_PRIME: begin
              box_total_nxt  = '0;
              box_count_nxt  = '0;
              dump_count_nxt = '0;
              x_nxt          = q_job.value;
              prime_nxt      = 1'b1;
              state_nxt      = ST_SEC;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          step_nxt = 3'd0;
          if (prime_r) begin
            gain_nxt  = div_quot;
            state_nxt = ST_MULGO;
          end else begin
            x_nxt     = sat_wide(div_quot);
            state_nxt = ST_SEC;
          end
        end
      end
      ST_SEC: begin
        step_nxt = 3'd0;
        if (sec_r >= nsec_lim) begin
          state_nxt = prime_r ? ST_IDLE : ST_EMIT;
        end else if (prime_r) begin
          num_nxt   = '0;
          den_nxt   = 35'sd1073741824;
          caddr_nxt = coef_addr(si, SLOT_B0);
          state_nxt = ST_GFETCH;
        end else begin
          caddr_nxt = coef_addr(si, step_slot(3'd0));
          state_nxt = ST_FETCH;
        end
      end
      ST_GFETCH: state_nxt = ST_GACC;
      ST_GACC: begin
        num_nxt = num_new;
        den_nxt = den_new;
        if (step_r == 3'd4) begin
          step_nxt = 3'd0;
          if (den_new == '0) begin
            gain_nxt  = '0;
            state_nxt = ST_MULGO;
          end else begin
            div_dvd   = {num_mag[32:0], 30'b0};
            div_dvs   = den_mag;
            div_neg   = num_new[34] ^ den_new[34];
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else begin
          step_nxt  = step_r + 3'd1;
          caddr_nxt = caddr_r + 6'd1;
          state_nxt = ST_GFETCH;
        end
      end
      ST_FETCH: state_nxt = ST_MULGO;
      ST_MULGO: begin
        mul_start = 1'b1;
        state_nxt = ST_MULWAIT;
      end
      ST_MULWAIT: begin
        if (mul_done) begin
          case (step_r)
            3'd0: y_nxt = prime_r ? mul_res : sat_add(mul_res, s1_r[si]);
            3'd1: t_nxt = mul_res;
            3'd2: begin
              if (prime_r) t_nxt = tt;
              else s1_nxt[si] = sat_add(tt, s2_r[si]);
            end
            3'd3: u_nxt = mul_res;
            default: begin
              s2_nxt[si] = s2n;
              if (prime_r) s1_nxt[si] = sat_add(t_r, s2n);
            end
          endcase
          if (step_r == 3'd4) begin
            x_nxt     = y_r;
            sec_nxt   = sec_r + 4'd1;
            state_nxt = ST_SEC;
          end else begin
            step_nxt  = step_r + 3'd1;
            caddr_nxt = coef_addr(si, step_slot(step_r + 3'd1));
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_EMIT: begin
        if (dcnt_inc < dec_len) begin
          dump_count_nxt = dcnt_inc[CNT_W-1:0];
          state_nxt      = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          dump_count_nxt = '0;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = x_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prime_r      <= 1'b0;
      sec_r        <= '0;
      step_r       <= '0;
      box_total_r  <= '0;
      box_count_r  <= '0;
      dump_count_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        s1_r[i] <= '0;
        s2_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      prime_r      <= prime_nxt;
      sec_r        <= sec_nxt;
      step_r       <= step_nxt;
      box_total_r  <= box_total_nxt;
      box_count_r  <= box_count_nxt;
      dump_count_r <= dump_count_nxt;
      out_valid_r  <= out_valid_nxt;
      s1_r         <= s1_nxt;
      s2_r         <= s2_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    gain_r     <= gain_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    caddr_r    <= caddr_nxt;
    out_data_r <= out_data_nxt;
  end

  // coefficient store; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[q_job.caddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[q_job.caddr] <= q_job.cword;
    coef_q_r <= coef_vld_r[caddr_r] ? coef_mem[caddr_r] : '0;
  end

  bbd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  bbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .neg   (div_neg),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/boxcar_biquad_decimator.sv
// Top level of the decimating boxcar and biquad cascade: configuration registers,
// front end, job queue and back end. Depends on bbd_pkg and all bbd_ modules.
//
// Input words are decoded by a front end and queued two deep, so the input side
// keeps flowing while the back end works until the queue is full. A sample that
// does not complete a boxcar and a coefficient write are handled directly in the
// idle state. A boxcar dump runs the bit-serial divider, then each active section in
// the shared 16x64 multiplier (five products plus coefficient fetch), and a direct
// value takes the same path without the division. A prime, per section, sums five
// coefficients, divides for the DC gain and runs five products. Results sit in an
// output register and the back end only waits there when an earlier result has not
// been taken.
module boxcar_biquad_decimator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,  // command
  // raw_sample[23:0], direct_value[71:24], coef_section[74:72],
  // coef_slot[77:75], coef_word[109:78], zero pad[111:110]
  input  logic [bbd_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // filtered
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbd_pkg::LEN_W-1:0]       cfg_data
);
  import bbd_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_len <= 13'd1;
      cfg_r.dec_len <= 13'd1;
      cfg_r.nsec    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOX_LEN: cfg_r.box_len <= cfg_data;
        CFG_DEC:     cfg_r.dec_len <= cfg_data;
        CFG_NSEC:    cfg_r.nsec    <= cfg_data[NSEC_W-1:0];
        default: ;
      endcase
    end
  end

  bbd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  bbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  bbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sim/bbd_checker.sv
// Watches the boxcar/biquad decimator channels, predicts each filtered word and
// compares it with the output. Depends on bbd_pkg; instantiated by tb.
module bbd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [1:0]                    in_tuser,
  input  logic [bbd_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [47:0]                   out_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbd_pkg::LEN_W-1:0]     cfg_data,
  output int                            pending,
  output int                            fails
);
  import bbd_pkg::*;

  logic [LEN_W-1:0]  box_len, dec_len;
  logic [NSEC_W-1:0] nsec;
  longint            box_total;
  int                box_cnt, dump_cnt;
  longint            dly1 [MAX_SECTIONS];
  longint            dly2 [MAX_SECTIONS];
  longint            coefs [COEF_DEPTH];
  logic [47:0]       filtered_q [$];

  assign pending = filtered_q.size();

  function automatic longint sat48(input longint v);
    if (v > longint'(SIG_MAX)) return longint'(SIG_MAX);
    if (v < longint'(SIG_MIN)) return longint'(SIG_MIN);
    return v;
  endfunction

  // round(a*b/2^30) ties away from zero, saturated
  function automatic longint mul_round(input longint a, input longint b);
    logic signed [127:0] sa, sb;
    logic [127:0]        ua, ub, m, lim;
    logic                neg;
    sa = a;
    sb = b;
    neg = (a < 0) != (b < 0);
    ua = (sa < 0) ? -sa : sa;
    ub = (sb < 0) ? -sb : sb;
    m = (ua * ub + (128'd1 << 29)) >> 30;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic int eff_len(input logic [LEN_W-1:0] v);
    return (v > MAX_RATIO) ? int'(MAX_RATIO) : int'(v);
  endfunction

  function automatic longint cf(input int sec, input logic [2:0] slot);
    return coefs[sec * 5 + int'(slot)];
  endfunction

  task automatic run_sections(inout longint x);
    longint y, t;
    for (int i = 0; i < int'(nsec) && i < MAX_SECTIONS; i++) begin
      y = sat48(mul_round(x, cf(i, SLOT_B0)) + dly1[i]);
      t = sat48(mul_round(x, cf(i, SLOT_B1)) - mul_round(y, cf(i, SLOT_A1)));
      dly1[i] = sat48(t + dly2[i]);
      dly2[i] = sat48(mul_round(x, cf(i, SLOT_B2)) - mul_round(y, cf(i, SLOT_A2)));
      x = y;
    end
  endtask

  task automatic prime_sections(input longint x);
    longint den, num, gain, y, t;
    int     n;
    box_total = 0;
    box_cnt = 0;
    dump_cnt = 0;
    n = (int'(nsec) > MAX_SECTIONS) ? MAX_SECTIONS : int'(nsec);
    for (int i = 0; i < n; i++) begin
      den = 64'sd1073741824 + cf(i, SLOT_A1) + cf(i, SLOT_A2);
      num = cf(i, SLOT_B0) + cf(i, SLOT_B1) + cf(i, SLOT_B2);
      gain = (den != 0) ? (num * 64'sd1073741824) / den : 0;
      y = mul_round(x, gain);
      t = sat48(mul_round(x, cf(i, SLOT_B1)) - mul_round(y, cf(i, SLOT_A1)));
      dly2[i] = sat48(mul_round(x, cf(i, SLOT_B2)) - mul_round(y, cf(i, SLOT_A2)));
      dly1[i] = sat48(t + dly2[i]);
      x = y;
    end
  endtask

  task automatic decimate(input longint y);
    dump_cnt++;
    if (dump_cnt >= eff_len(dec_len)) begin
      dump_cnt = 0;
      filtered_q.push_back(y[47:0]);
    end
  endtask

  task automatic predict_word(input cmd_t op, input logic [IN_DATA_W-1:0] d);
    longint x, v;
    logic   run_ok;
    logic [2:0] sec, slot;
    run_ok = box_len != 0 && dec_len != 0 && nsec <= NSEC_MAX;
    v = longint'($signed(d[71:24]));
    sec = d[74:72];
    slot = d[77:75];
    case (op)
      CMD_SAMPLE: if (run_ok) begin
        box_total += longint'($signed(d[23:0]));
        box_cnt++;
        if (box_cnt >= eff_len(box_len)) begin
          x = sat48((box_total * 65536) / longint'(eff_len(box_len)));
          box_total = 0;
          box_cnt = 0;
          run_sections(x);
          decimate(x);
        end
      end
      CMD_VALUE: if (run_ok) begin
        run_sections(v);
        decimate(v);
      end
      CMD_PRIME: prime_sections(v);
      default: if (slot <= SLOT_A2) begin
        coefs[int'(sec) * 5 + int'(slot)] = longint'($signed(d[109:78]));
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      box_len = 1;
      dec_len = 1;
      nsec = 0;
      box_total = 0;
      box_cnt = 0;
      dump_cnt = 0;
      foreach (dly1[i]) begin
        dly1[i] = 0;
        dly2[i] = 0;
      end
      foreach (coefs[i]) coefs[i] = 0;
      filtered_q.delete();
      fails <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BOX_LEN: box_len = cfg_data;
          CFG_DEC:     dec_len = cfg_data;
          CFG_NSEC:    nsec = cfg_data[NSEC_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $error("filtered: expected none got %h", out_tdata);
          fails <= fails + 1;
        end else if (filtered_q[0] !== out_tdata) begin
          $error("filtered: expected %h got %h", filtered_q[0], out_tdata);
          fails <= fails + 1;
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) predict_word(cmd_t'(in_tuser), in_tdata);
    end
  end
endmodule

### sim/tb.sv
// Stimulus and verdict for boxcar_biquad_decimator: directed words, then random
// phases over several settings. Depends on bbd_pkg, the block and bbd_checker.
module tb;
  import bbd_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic                   clk = 0;
  logic                   rst_n;
  logic                   in_tvalid, in_tready;
  logic [1:0]             in_tuser;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid, out_tready;
  logic [47:0]            out_tdata;
  logic                   cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LEN_W-1:0]       cfg_data;
  int                     pending, fails, quiet;
  logic                   calm;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  boxcar_biquad_decimator u_dut (.*);

  bbd_checker u_chk (.*);

  always @(posedge clk) out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input cmd_t op, input logic [IN_DATA_W-1:0] d);
    if (!calm && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= d;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack(input logic [23:0] smp,
      input logic [47:0] val, input logic [2:0] sec, input logic [2:0] slot,
      input logic [31:0] w);
    return {2'b00, w, slot, sec, val, smp};
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_word(input cmd_t op);
    logic [31:0] w;
    logic [2:0]  slot;
    logic [47:0] val;
    slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    w = $urandom;
    if ($urandom_range(0, 9) < 7) w = $signed(w) >>> ((slot >= SLOT_A1) ? 5 : 2);
    val = {16'($urandom), 32'($urandom)};
    if (op == CMD_PRIME || $urandom_range(0, 3) != 0) val = $signed(val) >>> 12;
    return pack(24'($urandom), val, 3'($urandom), slot, w);
  endfunction

  task automatic send_rand();
    int   r;
    cmd_t op;
    r = $urandom_range(0, 99);
    op = (r < 50) ? CMD_SAMPLE : (r < 75) ? CMD_VALUE : (r < 80) ? CMD_PRIME : CMD_COEF;
    send_word(op, rand_word(op));
  endtask

  // words without a result (primes above all) may still be in the back end
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_all(input int b, input int d, input int n);
    write_reg(CFG_BOX_LEN, LEN_W'(b));
    write_reg(CFG_DEC, LEN_W'(d));
    write_reg(CFG_NSEC, LEN_W'(n));
  endtask

  initial begin
    int bl [8] = '{1, 3, 2, 0, 1, 1, 4, 2};
    int dl [8] = '{1, 2, 3, 1, 0, 1, 1, 2};
    int nl [8] = '{8, 4, 8, 2, 3, 15, 0, 5};
    rst_n <= 0;
    in_tvalid <= 0;
    in_tuser <= CMD_SAMPLE;
    in_tdata <= '0;
    cfg_valid <= 0;
    cfg_index <= CFG_BOX_LEN;
    cfg_data <= '0;
    calm <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: coefficient extremes, bad addresses, signal extremes, priming
    send_word(CMD_COEF, pack('0, '0, 3'd0, SLOT_B0, 32'h4000_0000));
    send_word(CMD_COEF, pack('0, '0, 3'd0, SLOT_B1, 32'h7fff_ffff));
    send_word(CMD_COEF, pack('0, '0, 3'd0, SLOT_A1, 32'h8000_0000));
    send_word(CMD_COEF, pack('0, '0, 3'd7, SLOT_A2, 32'hc000_0000));
    send_word(CMD_COEF, pack('0, '0, 3'd1, 3'd7, 32'h1234_5678));
    send_word(CMD_COEF, pack('0, '0, 3'd1, 3'd5, 32'hffff_ffff));
    send_word(CMD_SAMPLE, pack(24'h7fffff, '1, '1, '1, '1));
    send_word(CMD_SAMPLE, pack(24'h800000, '0, '0, '0, '0));
    send_word(CMD_VALUE, pack('0, 48'h7fff_ffff_ffff, '0, '0, '0));
    send_word(CMD_VALUE, pack('0, 48'h8000_0000_0000, '0, '0, '0));
    drain();
    set_all(1, 1, 2);
    send_word(CMD_VALUE, pack('1, 48'h7fff_ffff_ffff, '1, '1, '1));
    send_word(CMD_VALUE, pack('0, 48'h8000_0000_0000, '0, '0, '0));
    send_word(CMD_SAMPLE, pack(24'h7fffff, '0, '0, '0, '0));
    send_word(CMD_SAMPLE, pack(24'h800000, '0, '0, '0, '0));
    // a1 + a2 = -1.0 gives a zero steady-state gain
    send_word(CMD_COEF, pack('0, '0, 3'd1, SLOT_A1, 32'hc000_0000));
    send_word(CMD_PRIME, pack('0, 48'h0001_0000_0000, '0, '0, '0));
    send_word(CMD_VALUE, pack('0, 48'h0001_0000_0000, '0, '0, '0));
    send_word(CMD_PRIME, pack('0, 48'h8000_0000_0000, '0, '0, '0));
    send_word(CMD_VALUE, pack('0, 48'h0000_0000_0000, '0, '0, '0));
    drain();

    for (int p = 0; p < 8; p++) begin
      set_all(bl[p], dl[p], nl[p]);
      calm <= (p == 2);
      for (int i = 0; i < 60; i++) send_rand();
      drain();
    end
    calm <= 0;

    // lengths above and at the ratio limit, then shortened below the running counters
    set_all(1, 8191, 1);
    for (int i = 0; i < 15; i++) send_word(CMD_VALUE, rand_word(CMD_VALUE));
    drain();
    write_reg(CFG_DEC, 13'd3);
    for (int i = 0; i < 10; i++) send_word(CMD_VALUE, rand_word(CMD_VALUE));
    drain();
    set_all(4096, 1, 3);
    for (int i = 0; i < 15; i++) send_word(CMD_SAMPLE, rand_word(CMD_SAMPLE));
    drain();
    write_reg(CFG_BOX_LEN, 13'd2);
    for (int i = 0; i < 30; i++) send_rand();
    drain();

    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

### boxcar_biquad_decimator.f
src/bbd_pkg.sv
src/bbd_front.sv
src/bbd_queue.sv
src/bbd_mul.sv
src/bbd_div.sv
src/bbd_back.sv
src/boxcar_biquad_decimator.sv
sim/bbd_checker.sv
sim/tb.sv
